@@ rtl/knob_mode_level_controller_core_defines.svh @@
// assertion macros shared by the knob controller rtl
// depends on a clock named clk and a synchronous reset named rst in the using module
`ifndef KNOB_MODE_LEVEL_CONTROLLER_CORE_DEFINES_SVH
`define KNOB_MODE_LEVEL_CONTROLLER_CORE_DEFINES_SVH

// condition holds in the same cycle as its trigger
`define KMLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after its trigger
`define KMLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/kmlc_pkg.sv @@
// shared types, constants and table lookup for the knob mode and level controller
// no dependencies
`timescale 1ns / 1ps

package kmlc_pkg;

  // number of modes the button cycles through (2 to 8)
  localparam int MODE_COUNT = 6;
  // modes that have an entry in the step and maximum tables
  localparam int TABLE_ENTRIES = 6;

  localparam int MODE_W  = 3;
  localparam int LEVEL_W = 8;
  localparam int COUNT_W = 16;
  localparam int TABLE_W = 48;
  localparam int DIR_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

  // reset values
  localparam logic [TABLE_W-1:0] STEP_TABLE_RESET = 48'd42967106051;
  localparam logic [TABLE_W-1:0] MAX_TABLE_RESET  = 48'd1096743373000;
  localparam logic [COUNT_W-1:0] LOCKOUT_RESET    = 16'd250;
  localparam logic [MODE_W-1:0]  MODE_RESET       = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET      = 8'd200;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TABLE    = 2'd0,
    CFG_MAX_TABLE     = 2'd1,
    CFG_LOCKOUT_TICKS = 2'd2
  } kmlc_cfg_idx_t;

  // step direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } kmlc_dir_t;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic button_pressed;
    logic ms_tick;
  } kmlc_sample_t;

  typedef struct packed {
    logic [TABLE_W-1:0] step_table;
    logic [TABLE_W-1:0] max_table;
    logic [COUNT_W-1:0] lockout_ticks;
  } kmlc_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] level;
    logic               step_locked;
    logic               lockout_running;
    logic [COUNT_W-1:0] lockout_count;
  } kmlc_state_t;

  // byte of a packed table for one mode, zero for modes without an entry
  function automatic logic [LEVEL_W-1:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                                    input logic [MODE_W-1:0] mode);
    logic [TABLE_W-1:0] shifted;
    shifted = tbl >> {mode, 3'b000};
    if (int'(mode) >= TABLE_ENTRIES) begin
      return '0;
    end
    return shifted[LEVEL_W-1:0];
  endfunction

endpackage

@@ rtl/knob_mode_level_controller_core.sv @@
// top level of the knob mode and level controller: sample register, state and result register
// depends on kmlc_pkg, kmlc_update and knob_mode_level_controller_core_defines.svh
`timescale 1ns / 1ps

// Takes one sample beat per clock while no result beat is stalled and gives one
// result beat per sample. A sample is captured in the input register, passes
// through the update logic and is written into the result register together with
// the mode, level, lock and lockout-timer registers, which are updated once per
// sample. While a result beat is stalled, one further sample can be held in the
// input register before in_stall rises. Configuration registers are written
// through cfg_write_en / cfg_index / cfg_data; writes to unknown indexes are
// ignored.
module knob_mode_level_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [kmlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmlc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            line_a,
  input  logic                            line_b,
  input  logic                            button_pressed,
  input  logic                            ms_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kmlc_pkg::MODE_W-1:0]     current_mode,
  output logic [kmlc_pkg::LEVEL_W-1:0]    level,
  output logic [kmlc_pkg::DIR_W-1:0]      step_dir
);
  import kmlc_pkg::*;
  `include "knob_mode_level_controller_core_defines.svh"

  kmlc_cfg_t    cfg;
  kmlc_state_t  state_q;
  kmlc_state_t  state_next;
  kmlc_sample_t sample_q;
  kmlc_dir_t    dir;
  logic         sample_valid;
  logic         sample_fire;
  logic         in_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_table <= STEP_TABLE_RESET;
      cfg.max_table <= MAX_TABLE_RESET;
      cfg.lockout_ticks <= LOCKOUT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_STEP_TABLE:    cfg.step_table <= cfg_data[TABLE_W-1:0];
        CFG_MAX_TABLE:     cfg.max_table <= cfg_data[TABLE_W-1:0];
        CFG_LOCKOUT_TICKS: cfg.lockout_ticks <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the sample moves on whenever the result register is free or being taken
  assign sample_fire = sample_valid && !(out_valid && out_stall);
  assign in_stall = sample_valid && out_valid && out_stall;
  assign in_fire = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_fire) begin
      sample_valid <= 1'b1;
    end else if (sample_fire) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_q <= '{line_a: line_a, line_b: line_b,
                    button_pressed: button_pressed, ms_tick: ms_tick};
    end
  end

  kmlc_update u_update (
    .state_q    (state_q),
    .sample     (sample_q),
    .cfg        (cfg),
    .state_next (state_next),
    .dir        (dir)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q.mode <= MODE_RESET;
      state_q.level <= LEVEL_RESET;
      state_q.step_locked <= 1'b0;
      state_q.lockout_running <= 1'b0;
      state_q.lockout_count <= '0;
    end else if (sample_fire) begin
      state_q <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sample_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      current_mode <= state_next.mode;
      level <= state_next.level;
      step_dir <= dir;
    end
  end

  // checks
  `KMLC_ASSERT_SAME(a_stall_only_when_full, in_stall, sample_valid && out_valid,
                    "input stalled while a stage is free")
  `KMLC_ASSERT_SAME(a_step_leaves_lock, out_valid && (step_dir != DIR_NONE),
                    state_q.step_locked, "pending step result without lock set")
  `KMLC_ASSERT_SAME(a_timer_starts_clear, $rose(state_q.lockout_running),
                    state_q.lockout_count == '0, "lockout timer started with stale count")
  `KMLC_ASSERT_SAME(a_mode_in_range, 1'b1,
                    (int'(state_q.mode) < MODE_COUNT) || (state_q.mode == MODE_RESET),
                    "mode register out of range")
  `KMLC_ASSERT_NEXT(a_result_follows_sample, sample_fire,
                    out_valid && (current_mode == state_q.mode) && (level == state_q.level),
                    "result register does not match updated state")

endmodule

@@ rtl/kmlc_update.sv @@
// next state and step direction for one sample of the knob controller
// depends on kmlc_pkg
`timescale 1ns / 1ps

module kmlc_update (
  input  kmlc_pkg::kmlc_state_t  state_q,
  input  kmlc_pkg::kmlc_sample_t sample,
  input  kmlc_pkg::kmlc_cfg_t    cfg,
  output kmlc_pkg::kmlc_state_t  state_next,
  output kmlc_pkg::kmlc_dir_t    dir
);
  import kmlc_pkg::*;

  kmlc_state_t       btn;
  logic [MODE_W:0]   mode_inc;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W-1:0] maxv;
  logic [LEVEL_W:0]   level_sum;

  // button press and lockout timer
  always_comb begin
    btn = state_q;
    mode_inc = {1'b0, state_q.mode} + {{MODE_W{1'b0}}, 1'b1};
    if (sample.button_pressed && !state_q.lockout_running) begin
      btn.lockout_running = 1'b1;
      btn.lockout_count = '0;
      if (int'(mode_inc) >= MODE_COUNT) begin
        btn.mode = '0;
      end else begin
        btn.mode = mode_inc[MODE_W-1:0];
      end
      btn.level = table_byte(cfg.max_table, btn.mode);
    end else if (state_q.lockout_running && sample.ms_tick) begin
      if (state_q.lockout_count < COUNT_LIMIT) begin
        btn.lockout_count = state_q.lockout_count + 16'd1;
      end
    end
    if (btn.lockout_running && btn.lockout_count >= cfg.lockout_ticks) begin
      btn.lockout_running = 1'b0;
    end
  end

  assign step = table_byte(cfg.step_table, btn.mode);
  assign maxv = table_byte(cfg.max_table, btn.mode);
  assign level_sum = {1'b0, btn.level} + {1'b0, step};

  // encoder step with saturation, then unlock on both lines high
  always_comb begin
    state_next = btn;
    dir = DIR_NONE;
    if (sample.line_a || sample.line_b) begin
      if (!sample.line_a && !btn.step_locked && btn.level < maxv) begin
        state_next.level = level_sum[LEVEL_W] ? LEVEL_LIMIT : level_sum[LEVEL_W-1:0];
        state_next.step_locked = 1'b1;
        dir = DIR_UP;
      end else if (!sample.line_b && !btn.step_locked) begin
        state_next.level = (btn.level > step) ? (btn.level - step) : '0;
        state_next.step_locked = 1'b1;
        dir = DIR_DOWN;
      end
    end
    if (sample.line_a && sample.line_b) begin
      state_next.step_locked = 1'b0;
    end
  end

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for knob_mode_level_controller_core: directed and random sample beats
// with its own model of mode, level, lock and lockout timer; depends on kmlc_pkg and the core
`timescale 1ns / 1ps

module tb_top;
  import kmlc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int LONG_LOCKOUT = 64;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] lvl;
    kmlc_dir_t          dir;
  } knob_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  line_a;
  logic                  line_b;
  logic                  button_pressed;
  logic                  ms_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic [MODE_W-1:0]     current_mode;
  logic [LEVEL_W-1:0]    level;
  logic [DIR_W-1:0]      step_dir;

  knob_mode_level_controller_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .line_a         (line_a),
    .line_b         (line_b),
    .button_pressed (button_pressed),
    .ms_tick        (ms_tick),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .current_mode   (current_mode),
    .level          (level),
    .step_dir       (step_dir)
  );

  // knob model state and its copy of the registers
  logic [TABLE_W-1:0] step_cfg;
  logic [TABLE_W-1:0] max_cfg;
  logic [COUNT_W-1:0] hold_cfg;
  logic [MODE_W-1:0]  cur_mode;
  logic [LEVEL_W-1:0] cur_level;
  logic               locked;
  logic               timer_run;
  logic [COUNT_W-1:0] timer_cnt;

  knob_result_t pending_results[$];

  int  mismatches;
  int  samples_sent;
  int  results_seen;
  int  mode_changes;
  int  steps_up;
  int  steps_down;
  int  quiet_cycles;
  bit  idle_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // table byte for a mode, zero past the end of the tables
  function automatic logic [LEVEL_W-1:0] entry_of(input logic [TABLE_W-1:0] tbl,
                                                  input logic [MODE_W-1:0] m);
    if (int'(m) >= TABLE_W / LEVEL_W) begin
      return '0;
    end
    return tbl[LEVEL_W*m +: LEVEL_W];
  endfunction

  // one sample through the knob model, expected beat queued
  task automatic advance_knob(input logic a, input logic b, input logic press,
                              input logic tick);
    logic [LEVEL_W-1:0] stp;
    logic [LEVEL_W-1:0] top;
    logic [LEVEL_W:0]   sum;
    kmlc_dir_t          dir;
    knob_result_t       res;
    dir = DIR_NONE;
    // button first, then the lockout timer
    if (press && !timer_run) begin
      timer_run = 1'b1;
      timer_cnt = '0;
      if (int'(cur_mode) + 1 >= MODE_COUNT) begin
        cur_mode = '0;
      end else begin
        cur_mode = cur_mode + 1'b1;
      end
      cur_level = entry_of(max_cfg, cur_mode);
      mode_changes++;
    end else if (timer_run && tick) begin
      if (timer_cnt != COUNT_LIMIT) begin
        timer_cnt = timer_cnt + 1'b1;
      end
    end
    if (timer_run && timer_cnt >= hold_cfg) begin
      timer_run = 1'b0;
    end
    // encoder last
    if (a || b) begin
      stp = entry_of(step_cfg, cur_mode);
      top = entry_of(max_cfg, cur_mode);
      if (!a && !locked && cur_level < top) begin
        sum = {1'b0, cur_level} + {1'b0, stp};
        cur_level = sum[LEVEL_W] ? LEVEL_LIMIT : sum[LEVEL_W-1:0];
        locked = 1'b1;
        dir = DIR_UP;
        steps_up++;
      end else if (!b && !locked) begin
        cur_level = (cur_level > stp) ? cur_level - stp : '0;
        locked = 1'b1;
        dir = DIR_DOWN;
        steps_down++;
      end
    end
    if (a && b) begin
      locked = 1'b0;
    end
    res.mode = cur_mode;
    res.lvl  = cur_level;
    res.dir  = dir;
    pending_results.push_back(res);
  endtask

  // result beat checker
  always @(posedge clk) begin
    knob_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
          $display("%0t: unexpected result beat mode=%0d level=%0d dir=%0d",
                   $realtime, current_mode, level, step_dir);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (current_mode !== exp_res.mode || level !== exp_res.lvl ||
            step_dir !== exp_res.dir) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("%0t: beat %0d mode exp %0d got %0d, level exp %0d got %0d, dir exp %0d got %0d",
                     $realtime, results_seen, exp_res.mode, current_mode,
                     exp_res.lvl, level, exp_res.dir, step_dir);
          end
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // one sample beat, sometimes with a random gap in front of it
  task automatic send_sample(input logic a, input logic b, input logic press,
                             input logic tick);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    line_a         <= a;
    line_b         <= b;
    button_pressed <= press;
    ms_tick        <= tick;
    do @(posedge clk); while (in_stall);
    advance_knob(a, b, press, tick);
    samples_sent++;
  endtask

  // hold off the sender until every expected beat is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers, block idle
  task automatic load_settings(input logic [TABLE_W-1:0] steps,
                               input logic [TABLE_W-1:0] maxima,
                               input logic [COUNT_W-1:0] hold);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_STEP_TABLE;
    cfg_data     <= steps;
    @(posedge clk);
    cfg_index    <= CFG_MAX_TABLE;
    cfg_data     <= maxima;
    @(posedge clk);
    cfg_index    <= CFG_LOCKOUT_TICKS;
    cfg_data     <= CFG_DATA_W'(hold);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    step_cfg = steps;
    max_cfg  = maxima;
    hold_cfg = hold;
  endtask

  function automatic logic [TABLE_W-1:0] random_table();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic press_roll();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic logic tick_roll();
    return $urandom_range(0, 1) == 1;
  endfunction

  // detent movement: rest, one line low, maybe both low, other line low, rest
  task automatic random_gesture();
    logic up_first;
    up_first = 1'($urandom_range(0, 1));
    send_sample(1'b1, 1'b1, press_roll(), tick_roll());
    send_sample(!up_first, up_first, press_roll(), tick_roll());
    if ($urandom_range(0, 1) == 1) begin
      send_sample(1'b0, 1'b0, press_roll(), tick_roll());
    end
    send_sample(up_first, !up_first, press_roll(), tick_roll());
    send_sample(1'b1, 1'b1, press_roll(), tick_roll());
  endtask

  // defaults after reset: steps, lock, unlock, press and ignored press
  task automatic test_reset_state();
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1);
    wait_for_results();
  endtask

  // zero lockout, zero steps and maxima, repeated presses advance the mode and wrap it
  task automatic test_zero_lockout();
    load_settings('0, '0, '0);
    repeat (MODE_COUNT + 1) send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // level saturation at zero, step past the mode maximum, at-maximum hold
  task automatic test_saturation();
    load_settings({TABLE_W{1'b1}}, {TABLE_W{1'b1}}, 16'd1);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    wait_for_results();
    load_settings({6{8'd200}}, {6{8'd100}}, 16'd1);
    send_sample(1'b1, 1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // long lockout: presses ignored on every tick until the timer runs out
  task automatic test_long_lockout();
    idle_on = 1'b0;
    load_settings(random_table(), random_table(), COUNT_W'(LONG_LOCKOUT));
    send_sample(1'b1, 1'b1, 1'b1, 1'b0);
    repeat (LONG_LOCKOUT) begin
      send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b1);
    end
    send_sample(1'b1, 1'b1, 1'b1, 1'b1);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // random traffic over several register settings, quiet in the last phase
  task automatic test_random_traffic();
    int phase;
    int start;
    int pause_at;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_settings(STEP_TABLE_RESET, MAX_TABLE_RESET, LOCKOUT_RESET);
        1: load_settings(random_table(), random_table(), COUNT_W'($urandom_range(0, 8)));
        2: load_settings({TABLE_W{1'b1}}, random_table(), COUNT_W'($urandom_range(0, 3)));
        3: load_settings('0, random_table(), COUNT_W'($urandom_range(0, 12)));
        default: begin
          idle_on = 1'b0;
          load_settings(random_table(), random_table(), COUNT_W'($urandom_range(0, 6)));
        end
      endcase
      start = samples_sent;
      pause_at = $urandom_range(50, 250);
      while (samples_sent - start < 300) begin
        if (samples_sent - start >= pause_at && pause_at > 0) begin
          wait_for_results();
          pause_at = 0;
        end
        if ($urandom_range(0, 9) < 7) begin
          random_gesture();
        end else begin
          send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      wait_for_results();
    end
  endtask

  // reset and test sequence
  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_index      <= CFG_STEP_TABLE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    line_a         <= 1'b0;
    line_b         <= 1'b0;
    button_pressed <= 1'b0;
    ms_tick        <= 1'b0;
    out_stall      <= 1'b0;
    quiet_cycles   <= 0;
    idle_on = 1'b1;
    step_cfg  = STEP_TABLE_RESET;
    max_cfg   = MAX_TABLE_RESET;
    hold_cfg  = LOCKOUT_RESET;
    cur_mode  = MODE_RESET;
    cur_level = LEVEL_RESET;
    locked    = 1'b0;
    timer_run = 1'b0;
    timer_cnt = '0;
    mismatches   = 0;
    samples_sent = 0;
    results_seen = 0;
    mode_changes = 0;
    steps_up     = 0;
    steps_down   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_zero_lockout();
    test_saturation();
    test_long_lockout();
    test_random_traffic();

    wait_for_results();
    if (pending_results.size() != 0) begin
      mismatches++;
    end
    $display("summary: %0d samples, %0d results checked, %0d mismatches",
             samples_sent, results_seen, mismatches);
    $display("summary: %0d mode changes, %0d steps up, %0d steps down, five register settings",
             mode_changes, steps_up, steps_down);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
